// ===== sv/qsov_pkg.sv =====
`default_nettype none

package qsov_pkg;

    localparam int SENSORS = 4;

    // register indexes of the configuration port
    localparam logic REG_SIGMA = 1'b0;

    localparam logic [7:0] SIGMA_RESET = 8'd9;

    // classification of one accepted word
    typedef struct packed {
        logic [SENSORS-1:0] alive;
        logic [2:0]         cnt;
    } t_cls;

    // queue status
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

`default_nettype wire

// ===== sv/quad_sensor_outlier_voter.sv =====
`default_nettype none

// quad sensor outlier voter: fuses four redundant signed readings into one
// value. sensors flagged in i_fault_mask are dropped first; with three or
// four usable readings each one, in sensor order, is tested against the
// others ((n*d - S)^2 < sigma_limit_squared * sum (n*o - S)^2, others
// pairwise distinct) and the first failing one is dropped, at most twice.
// the output word is the floor mean of the survivors, or the last fused
// value with o_held set when no sensor is usable. a front stage classifies
// accepted words into a two-word queue; the back stage runs the tests and
// the mean and holds the result in an output register, so one word can
// wait at the output while the next is worked on. each test is a pass
// through deviations, squares, sums and a scaled compare, up to seven
// passes, and a mean over three survivors adds a reciprocal multiply by
// one third. sigma_limit_squared sits at byte address 0 and resets to 9;
// write it only while the block is idle.

module quad_sensor_outlier_voter #(
    parameter int SAMPLE_WIDTH = 24
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    // configuration port
    input  wire                            psel,
    input  wire                            penable,
    input  wire                            pwrite,
    input  wire  [2:0]                     paddr,
    input  wire  [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    // input words
    input  wire                            i_valid,
    output logic                           o_ready,
    input  wire  signed [SAMPLE_WIDTH-1:0] i_sample_zero,
    input  wire  signed [SAMPLE_WIDTH-1:0] i_sample_one,
    input  wire  signed [SAMPLE_WIDTH-1:0] i_sample_two,
    input  wire  signed [SAMPLE_WIDTH-1:0] i_sample_three,
    input  wire  [3:0]                     i_fault_mask,
    // result words
    output logic                           o_valid,
    input  wire                            i_ready,
    output logic signed [SAMPLE_WIDTH-1:0] o_fused_value,
    output logic [3:0]                     o_used_mask,
    output logic                           o_held
);

    logic [7:0]                                      r_sigma;
    logic [qsov_pkg::SENSORS-1:0][SAMPLE_WIDTH-1:0]  smp;
    logic [qsov_pkg::SENSORS-1:0][SAMPLE_WIDTH-1:0]  q_smp;
    qsov_pkg::t_cls                                  q_cls;
    qsov_pkg::t_qstat                                q_stat;
    logic                                            q_valid;
    logic                                            q_ready;
    logic [SAMPLE_WIDTH-1:0]                         fused;

    // register file: one 8-bit register, word index taken from paddr[2]
    assign pready = 1'b1;
    assign prdata = (paddr[2] == qsov_pkg::REG_SIGMA) ? {24'b0, r_sigma} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sigma <= qsov_pkg::SIGMA_RESET;
        end else if (psel && penable && pwrite && pready
                     && (paddr[2] == qsov_pkg::REG_SIGMA)) begin
            r_sigma <= pwdata[7:0];
        end
    end

    assign smp = {i_sample_three, i_sample_two, i_sample_one, i_sample_zero};

    // front: accept and classify into the queue
    qsov_front #(
        .W(SAMPLE_WIDTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_smp     (smp),
        .i_fault   (i_fault_mask),
        .o_q_valid (q_valid),
        .i_q_ready (q_ready),
        .o_q_smp   (q_smp),
        .o_q_cls   (q_cls),
        .o_stat    (q_stat)
    );

    // back: outlier tests, mean and output register
    qsov_back #(
        .W(SAMPLE_WIDTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_sigma   (r_sigma),
        .i_q_valid (q_valid),
        .o_q_ready (q_ready),
        .i_q_smp   (q_smp),
        .i_q_cls   (q_cls),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_fused   (fused),
        .o_used    (o_used_mask),
        .o_held    (o_held)
    );

    assign o_fused_value = fused;

    // a held word uses no sensor, a fused word uses at least one
    a_held_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_held == (o_used_mask == 4'd0)))
        else $error("held flag and used mask disagree");

    // the queue is never full and empty at once
    a_queue_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue status inconsistent");

    // a full queue turns the input away
    a_queue_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.full |-> !o_ready)
        else $error("input accepted into a full queue");

endmodule

`default_nettype wire

// ===== sv/qsov_front.sv =====
`default_nettype none

module qsov_front #(
    parameter int W = 24
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_valid,
    output logic                                 o_ready,
    input  wire  [qsov_pkg::SENSORS-1:0][W-1:0]  i_smp,
    input  wire  [qsov_pkg::SENSORS-1:0]         i_fault,
    output logic                                 o_q_valid,
    input  wire                                  i_q_ready,
    output logic [qsov_pkg::SENSORS-1:0][W-1:0]  o_q_smp,
    output qsov_pkg::t_cls                       o_q_cls,
    output qsov_pkg::t_qstat                     o_stat
);

    logic [1:0][qsov_pkg::SENSORS-1:0][W-1:0] r_smp;
    qsov_pkg::t_cls [1:0]                      r_cls;
    logic                                      r_wp;
    logic                                      r_rp;
    logic [1:0]                                r_cnt;
    qsov_pkg::t_cls                            cls;
    logic                                      push;
    logic                                      pop;

    // usable sensors and their count
    always_comb begin
        cls.alive = ~i_fault;
        cls.cnt   = 3'(cls.alive[0]) + 3'(cls.alive[1]) + 3'(cls.alive[2])
                  + 3'(cls.alive[3]);
    end

    assign o_ready   = (r_cnt != 2'd2);
    assign o_q_valid = (r_cnt != 2'd0);
    assign push      = i_valid && o_ready;
    assign pop       = o_q_valid && i_q_ready;
    assign o_q_smp   = r_smp[r_rp];
    assign o_q_cls   = r_cls[r_rp];
    assign o_stat.full  = (r_cnt == 2'd2);
    assign o_stat.empty = (r_cnt == 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_smp[r_wp] <= i_smp;
            r_cls[r_wp] <= cls;
        end
    end

endmodule

`default_nettype wire

// ===== sv/qsov_back.sv =====
`default_nettype none

module qsov_back #(
    parameter int W = 24
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire  [7:0]                           i_sigma,
    input  wire                                  i_q_valid,
    output logic                                 o_q_ready,
    input  wire  [qsov_pkg::SENSORS-1:0][W-1:0]  i_q_smp,
    input  wire  qsov_pkg::t_cls                 i_q_cls,
    output logic                                 o_valid,
    input  wire                                  i_ready,
    output logic [W-1:0]                         o_fused,
    output logic [qsov_pkg::SENSORS-1:0]         o_used,
    output logic                                 o_held
);

    localparam int SW  = W + 2;
    localparam int SQW = 2 * SW;
    localparam int RW  = SQW + 2;
    localparam int PW  = RW + 8;
    // reciprocal of three: shift chosen so that 3 * DMUL = 2^DSH + 1
    localparam int DSH = (SW % 2 == 0) ? SW + 1 : SW + 2;
    localparam int DPW = 2 * SW + 1;
    localparam logic [SW:0]   DMUL = (SW + 1)'(((64'd1 << DSH) + 64'd1) / 64'd3);
    localparam logic [SW-1:0] DOFF = SW'(3) << (W - 1);
    localparam logic [SW-1:0] QOFF = SW'(1) << (W - 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_PREP, ST_SQ, ST_SUM, ST_CMP, ST_MEAN, ST_DIV, ST_DFIX, ST_FIN
    } t_state;

    t_state                                r_state;
    logic [qsov_pkg::SENSORS-1:0][W-1:0]   r_v;
    logic [qsov_pkg::SENSORS-1:0]          r_alive;
    logic [qsov_pkg::SENSORS-1:0]          r_cand;
    logic [qsov_pkg::SENSORS-1:0]          r_oth;
    logic [2:0]                            r_n;
    logic [qsov_pkg::SENSORS-1:0][SW-1:0]  r_mag;
    logic [qsov_pkg::SENSORS-1:0][SQW-1:0] r_sq;
    logic                                  r_dup;
    logic [SQW-1:0]                        r_lhs;
    logic [RW-1:0]                         r_rhs;
    logic [SW-1:0]                         r_dq;
    logic [DPW-1:0]                        r_dprod;
    logic [W-1:0]                          r_res;
    logic                                  r_held;
    logic [W-1:0]                          r_last;
    logic                                  r_ovalid;
    logic [W-1:0]                          r_ofused;
    logic [qsov_pkg::SENSORS-1:0]          r_oused;
    logic                                  r_oheld;

    logic [qsov_pkg::SENSORS-1:0]          others;
    logic [1:0]                            k;
    logic signed [SW-1:0]                  s_oth;
    logic signed [SW-1:0]                  s_all;
    logic [qsov_pkg::SENSORS-1:0][SW-1:0]  mag;
    logic                                  dup;
    logic [SQW-1:0]                        lhs;
    logic [RW-1:0]                         rhs;
    logic [PW-1:0]                         prod;
    logic                                  pass;
    logic [qsov_pkg::SENSORS-1:0]          higher;
    logic [qsov_pkg::SENSORS-1:0]          nxt;
    logic [qsov_pkg::SENSORS-1:0]          alive2;
    logic [qsov_pkg::SENSORS-1:0]          q_alive;
    logic [SW-1:0]                         qfix;

    // deviations of every lane against the sum of the others
    always_comb begin
        logic signed [SW-1:0] vx;
        logic signed [SW-1:0] kv;
        logic signed [SW:0]   d;
        others = r_alive & ~r_cand;
        k      = 2'(others[0]) + 2'(others[1]) + 2'(others[2]) + 2'(others[3]);
        s_oth  = '0;
        s_all  = '0;
        for (int i = 0; i < qsov_pkg::SENSORS; i++) begin
            vx = {{2{r_v[i][W-1]}}, r_v[i]};
            if (others[i]) begin
                s_oth = s_oth + vx;
            end
            if (r_alive[i]) begin
                s_all = s_all + vx;
            end
        end
        for (int i = 0; i < qsov_pkg::SENSORS; i++) begin
            vx = {{2{r_v[i][W-1]}}, r_v[i]};
            kv = (k[0] ? vx : '0) + (k[1] ? (vx <<< 1) : '0);
            d  = {kv[SW-1], kv} - {s_oth[SW-1], s_oth};
            mag[i] = d[SW] ? SW'(-d) : d[SW-1:0];
        end
        dup = 1'b0;
        for (int a = 0; a < qsov_pkg::SENSORS; a++) begin
            for (int b = a + 1; b < qsov_pkg::SENSORS; b++) begin
                if (others[a] && others[b] && (r_v[a] == r_v[b])) begin
                    dup = 1'b1;
                end
            end
        end
    end

    always_comb begin
        lhs = '0;
        rhs = '0;
        for (int i = 0; i < qsov_pkg::SENSORS; i++) begin
            if (r_cand[i]) begin
                lhs = lhs | r_sq[i];
            end
            if (r_oth[i]) begin
                rhs = rhs + RW'(r_sq[i]);
            end
        end
    end

    assign prod    = {8'b0, r_rhs} * {{(PW-8){1'b0}}, i_sigma};
    assign pass    = !r_dup && ({{(PW-SQW){1'b0}}, r_lhs} < prod);
    assign higher  = r_alive & ~(r_cand | (r_cand - 4'd1));
    assign nxt     = higher & (~higher + 4'd1);
    assign alive2  = r_alive & ~r_cand;
    assign q_alive = i_q_cls.alive;
    // quotient of the offset sum by three, offset taken back out
    assign qfix    = SW'(r_dprod >> DSH) - QOFF;

    assign o_q_ready = (r_state == ST_IDLE);
    assign o_valid   = r_ovalid;
    assign o_fused   = r_ofused;
    assign o_used    = r_oused;
    assign o_held    = r_oheld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_last   <= '0;
        end else begin
            if (r_ovalid && i_ready && (r_state != ST_FIN)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        r_v     <= i_q_smp;
                        r_alive <= q_alive;
                        r_n     <= i_q_cls.cnt;
                        r_cand  <= q_alive & (~q_alive + 4'd1);
                        if (i_q_cls.cnt >= 3'd3) begin
                            r_state <= ST_PREP;
                        end else begin
                            r_state <= ST_MEAN;
                        end
                    end
                end
                ST_PREP: begin
                    r_mag   <= mag;
                    r_dup   <= dup;
                    r_oth   <= others;
                    r_state <= ST_SQ;
                end
                ST_SQ: begin
                    for (int i = 0; i < qsov_pkg::SENSORS; i++) begin
                        r_sq[i] <= {{SW{1'b0}}, r_mag[i]} * {{SW{1'b0}}, r_mag[i]};
                    end
                    r_state <= ST_SUM;
                end
                ST_SUM: begin
                    r_lhs   <= lhs;
                    r_rhs   <= rhs;
                    r_state <= ST_CMP;
                end
                ST_CMP: begin
                    if (pass) begin
                        if (nxt == '0) begin
                            r_state <= ST_MEAN;
                        end else begin
                            r_cand  <= nxt;
                            r_state <= ST_PREP;
                        end
                    end else begin
                        r_alive <= alive2;
                        r_n     <= r_n - 3'd1;
                        r_cand  <= alive2 & (~alive2 + 4'd1);
                        if (r_n == 3'd3) begin
                            r_state <= ST_MEAN;
                        end else begin
                            r_state <= ST_PREP;
                        end
                    end
                end
                ST_MEAN: begin
                    case (r_n)
                        3'd0: begin
                            r_res   <= r_last;
                            r_held  <= 1'b1;
                            r_state <= ST_FIN;
                        end
                        3'd1: begin
                            r_res   <= s_all[W-1:0];
                            r_held  <= 1'b0;
                            r_state <= ST_FIN;
                        end
                        3'd2: begin
                            r_res   <= W'(s_all >>> 1);
                            r_held  <= 1'b0;
                            r_state <= ST_FIN;
                        end
                        3'd4: begin
                            r_res   <= W'(s_all >>> 2);
                            r_held  <= 1'b0;
                            r_state <= ST_FIN;
                        end
                        default: begin
                            // divide by three on an offset, non-negative sum
                            r_dq    <= s_all + DOFF;
                            r_held  <= 1'b0;
                            r_state <= ST_DIV;
                        end
                    endcase
                end
                ST_DIV: begin
                    r_dprod <= {{(SW+1){1'b0}}, r_dq} * {{SW{1'b0}}, DMUL};
                    r_state <= ST_DFIX;
                end
                ST_DFIX: begin
                    r_res   <= qfix[W-1:0];
                    r_state <= ST_FIN;
                end
                ST_FIN: begin
                    if (!r_ovalid || i_ready) begin
                        r_ovalid <= 1'b1;
                        r_ofused <= r_res;
                        r_oused  <= r_held ? '0 : r_alive;
                        r_oheld  <= r_held;
                        if (!r_held) begin
                            r_last <= r_res;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`default_nettype none

module tb;

    localparam int SW = 24;
    localparam int RANDOM_WORDS = 1600;
    localparam int STALL_LIMIT = 20000;

    logic           i_clk;
    logic           i_rst_n;
    logic           psel;
    logic           penable;
    logic           pwrite;
    logic [2:0]     paddr;
    logic [31:0]    pwdata;
    logic [31:0]    prdata;
    logic           pready;
    logic           i_valid;
    logic           o_ready;
    logic [SW-1:0]  i_sample_zero;
    logic [SW-1:0]  i_sample_one;
    logic [SW-1:0]  i_sample_two;
    logic [SW-1:0]  i_sample_three;
    logic [3:0]     i_fault_mask;
    logic           o_valid;
    logic           i_ready;
    logic [SW-1:0]  o_fused_value;
    logic [3:0]     o_used_mask;
    logic           o_held;

    quad_sensor_outlier_voter #(.SAMPLE_WIDTH(SW)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_sample_zero(i_sample_zero), .i_sample_one(i_sample_one),
        .i_sample_two(i_sample_two), .i_sample_three(i_sample_three),
        .i_fault_mask(i_fault_mask),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_fused_value(o_fused_value), .o_used_mask(o_used_mask), .o_held(o_held)
    );

    // one fused result as the block should give it
    typedef struct packed {
        logic [SW-1:0] fused;
        logic [3:0]    used;
        logic          held;
    } t_fusion;

    // one input word plus an optional typed-in expectation
    typedef struct {
        logic [SW-1:0] s0, s1, s2, s3;
        logic [3:0]    faults;
        bit            known;
        t_fusion       want;
    } t_sensor_row;

    t_fusion        fusion_q[$];
    t_sensor_row    rows[$];
    logic [7:0]     sigma_sq;
    logic [SW-1:0]  prev_fused;
    int             mismatches;
    int             words_in;
    int             words_out;
    int             held_seen;
    int             idle_cycles;
    bit             timed_out;

    // clock: 4 high, 4 low
    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
        $display("mismatch on %s at result %0d: got %0h expected %0h",
                 what, words_out, got, exp);
        mismatches++;
    endtask

    // squared distance, 96 bits is plenty for 3 * 2^24 magnitudes
    function automatic logic [95:0] sq(input longint v);
        logic [95:0] m;
        m = (v < 0) ? 96'(-v) : 96'(v);
        return m * m;
    endfunction

    // does candidate at position pos survive against the rest of the list
    function automatic bit survives(input longint vals[4], input int lst[4], input int n,
                                    input int pos);
        longint others[3];
        int k;
        longint s;
        logic [95:0] lhs;
        logic [95:0] rhs;
        k = 0;
        s = 0;
        rhs = '0;
        for (int i = 0; i < n; i++)
            if (i != pos) begin
                others[k] = vals[lst[i]];
                k++;
            end
        for (int i = 0; i < k; i++)
            for (int j = i + 1; j < k; j++)
                if (others[i] == others[j])
                    return 1'b0;
        for (int i = 0; i < k; i++)
            s += others[i];
        lhs = sq(k * vals[lst[pos]] - s);
        for (int i = 0; i < k; i++)
            rhs += sq(k * others[i] - s);
        rhs = rhs * sigma_sq;
        return lhs < rhs;
    endfunction

    // full voter behavior; updates prev_fused
    function automatic t_fusion vote(input t_sensor_row r);
        longint vals[4];
        int lst[4];
        int n;
        int drop;
        bit done;
        longint sum;
        longint q;
        t_fusion f;
        vals[0] = longint'($signed(r.s0));
        vals[1] = longint'($signed(r.s1));
        vals[2] = longint'($signed(r.s2));
        vals[3] = longint'($signed(r.s3));
        for (int i = 0; i < 4; i++)
            lst[i] = i;
        n = 4;
        done = 1'b0;
        sum = 0;
        f.used = '0;
        while (!done && n > 2) begin
            drop = -1;
            for (int i = 0; i < n; i++)
                if (drop < 0 && r.faults[lst[i]])
                    drop = i;
            if (drop < 0) begin
                for (int i = 0; i < n; i++)
                    if (drop < 0 && !survives(vals, lst, n, i))
                        drop = i;
                if (drop < 0)
                    done = 1'b1;
            end else begin
                // faulty drops never end the loop by themselves
                for (int i = drop; i + 1 < n; i++)
                    lst[i] = lst[i + 1];
                n--;
                drop = -2;
            end
            if (drop >= 0) begin
                for (int i = drop; i + 1 < n; i++)
                    lst[i] = lst[i + 1];
                n--;
                if (n == 2)
                    done = 1'b1;
            end
        end
        if (!done) begin
            int i;
            i = 0;
            while (i < n) begin
                if (r.faults[lst[i]]) begin
                    for (int j = i; j + 1 < n; j++)
                        lst[j] = lst[j + 1];
                    n--;
                end else begin
                    i++;
                end
            end
        end
        if (n == 0) begin
            f.fused = prev_fused;
            f.held = 1'b1;
        end else begin
            for (int i = 0; i < n; i++) begin
                sum += vals[lst[i]];
                f.used[lst[i]] = 1'b1;
            end
            q = sum / n;
            if (sum % n != 0 && sum < 0)
                q--;
            f.fused = q[SW-1:0];
            f.held = 1'b0;
            prev_fused = f.fused;
        end
        return f;
    endfunction

    task automatic reg_write(input logic [7:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'(4 * qsov_pkg::REG_SIGMA);
        pwdata <= {24'h0, v};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sigma_sq = v;
    endtask

    // send one word: random gap, then hold valid until accepted
    task automatic send_word(input t_sensor_row r);
        t_fusion f;
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_sample_zero <= r.s0;
        i_sample_one <= r.s1;
        i_sample_two <= r.s2;
        i_sample_three <= r.s3;
        i_fault_mask <= r.faults;
        i_valid <= 1'b1;
        do
            @(posedge i_clk);
        while (!o_ready);
        f = vote(r);
        if (r.known && f != r.want)
            $display("table row disagrees with predictor for word %0d", words_in);
        fusion_q.push_back(r.known ? r.want : f);
        words_in++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (fusion_q.size() != 0 && !timed_out)
            @(negedge i_clk);
        // up to seven test passes plus the divide
        repeat (80) @(negedge i_clk);
    endtask

    function automatic logic [SW-1:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return {1'b1, {(SW-1){1'b0}}};
            1: return {1'b0, {(SW-1){1'b1}}};
            2: return SW'($urandom_range(0, 15)) - SW'(8);
            default: return SW'($urandom);
        endcase
    endfunction

    // mostly close readings around a base with the odd outlier
    function automatic t_sensor_row rand_row();
        t_sensor_row r;
        logic [SW-1:0] base;
        logic [SW-1:0] s[4];
        int spread;
        base = rand_sample();
        spread = 1 << $urandom_range(0, 12);
        for (int i = 0; i < 4; i++) begin
            s[i] = base + SW'($urandom_range(0, spread)) - SW'(spread / 2);
            if ($urandom_range(0, 5) == 0)
                s[i] = rand_sample();
            if ($urandom_range(0, 9) == 0 && i > 0)
                s[i] = s[i - 1];
        end
        r.s0 = s[0];
        r.s1 = s[1];
        r.s2 = s[2];
        r.s3 = s[3];
        r.faults = ($urandom_range(0, 2) == 0) ? 4'($urandom) : 4'h0;
        r.known = 1'b0;
        r.want = '{default: '0};
        return r;
    endfunction

    function automatic t_sensor_row row(input int a, input int b, input int c, input int d,
                                        input logic [3:0] fm);
        t_sensor_row r;
        r.s0 = SW'(a);
        r.s1 = SW'(b);
        r.s2 = SW'(c);
        r.s3 = SW'(d);
        r.faults = fm;
        r.known = 1'b0;
        r.want = '{default: '0};
        return r;
    endfunction

    function automatic t_sensor_row known_row(input int a, input int b, input int c, input int d,
                                              input logic [3:0] fm, input int fv,
                                              input logic [3:0] um, input logic h);
        t_sensor_row r;
        r = row(a, b, c, d, fm);
        r.known = 1'b1;
        r.want.fused = SW'(fv);
        r.want.used = um;
        r.want.held = h;
        return r;
    endfunction

    // result side: random wait per word, compare at the rising edge
    initial begin
        t_fusion e;
        int gap;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do
                @(posedge i_clk);
            while (!(i_rst_n && o_valid));
            if (fusion_q.size() == 0) begin
                report("unexpected result", 32'(o_fused_value), 32'd0);
            end else begin
                e = fusion_q.pop_front();
                if (o_fused_value !== e.fused)
                    report("fused_value", 32'(o_fused_value), 32'(e.fused));
                if (o_used_mask !== e.used)
                    report("used_mask", 32'(o_used_mask), 32'(e.used));
                if (o_held !== e.held)
                    report("held", 32'(o_held), 32'(e.held));
                if (e.held)
                    held_seen++;
            end
            words_out++;
        end
    end

    // watchdog: cycles without any accepted word
    initial begin
        idle_cycles = 0;
        timed_out = 1'b0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                timed_out = 1'b1;
                $display("** quad_sensor_outlier_voter: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        logic [7:0] sigmas[5];
        mismatches = 0;
        words_in = 0;
        words_out = 0;
        held_seen = 0;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        i_valid = 1'b0;
        i_sample_zero = '0;
        i_sample_one = '0;
        i_sample_two = '0;
        i_sample_three = '0;
        i_fault_mask = '0;
        sigma_sq = qsov_pkg::SIGMA_RESET;
        prev_fused = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table
        rows.push_back(known_row(5, 6, 7, 8, 4'hf, 0, 4'h0, 1'b1));          // all faulty at reset
        rows.push_back(known_row(1, 2, 3, -77, 4'h7, -77, 4'h8, 1'b0));      // one usable sensor
        rows.push_back(known_row(9, 9, 9, 9, 4'hf, -77, 4'h0, 1'b1));        // held value
        rows.push_back(known_row(-3, 0, 0, 0, 4'h6, -2, 4'h9, 1'b0));        // two, floor mean
        rows.push_back(known_row(-8388608, -8388608, 0, 0, 4'hc, -8388608, 4'h3, 1'b0));
        rows.push_back(known_row(8388607, 8388607, 0, 0, 4'ha, 4194303, 4'h5, 1'b0));
        rows.push_back(known_row(4, 0, 0, 0, 4'he, 4, 4'h1, 1'b0));          // only first sensor
        rows.push_back(row(100, 101, 102, 5000, 4'h0));                      // outlier on sensor 3
        rows.push_back(row(9000, 101, 102, 103, 4'h0));                      // outlier on sensor 0
        rows.push_back(row(100, 101, 103, 106, 4'h0));
        rows.push_back(row(7, 7, 7, 7, 4'h0));                               // equal others
        rows.push_back(row(100, 101, 5000, 0, 4'h8));                        // three usable
        rows.push_back(row(-8388608, 8388607, -8388608, 8388607, 4'h0));
        rows.push_back(row(8388607, -8388608, 1, -1, 4'h1));
        rows.push_back(row(-1, -2, -3, -4, 4'h0));
        rows.push_back(row(10, 20, 30, 40, 4'h2));
        foreach (rows[i])
            send_word(rows[i]);

        // sender holds off until every result is back
        drain();

        sigmas[0] = 8'd1;
        sigmas[1] = 8'd255;
        sigmas[2] = 8'd0;
        sigmas[3] = 8'd9;
        sigmas[4] = 8'($urandom_range(2, 254));
        for (int p = 0; p < 5; p++) begin
            reg_write(sigmas[p]);
            if (p == 2) begin
                // zero limit: every test fails
                send_word(row(100, 101, 102, 103, 4'h0));
                send_word(row(1, 2, 3, 0, 4'h8));
            end
            for (int i = 0; i < RANDOM_WORDS / 5; i++)
                send_word(rand_row());
            drain();
        end

        $display("fed %0d words over five sigma limits, %0d results checked, %0d held",
                 words_in, words_out, held_seen);
        if (mismatches == 0 && fusion_q.size() == 0) begin
            $display("** quad_sensor_outlier_voter: PASSED **");
        end else begin
            $display("** quad_sensor_outlier_voter: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire
